>>> rtl/dtmf_pkg.sv
package dtmf_pkg;

	localparam int unsigned SYM_W    = 4;
	localparam int unsigned AMP_W    = 15;
	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned ADDR_W   = 3;
	localparam int unsigned DATA_W   = 32;

	localparam logic [AMP_W-1:0] AMP_RESET = 15'd16383;

	// register index taken from paddr[2]
	localparam logic REG_AMPLITUDE = 1'b0;

	localparam logic [63:0] SAMPLE_RATE = 64'd44100;
	localparam logic [63:0] FULL_SCALE  = 64'd32767;
	localparam logic [63:0] PI_Q30      = 64'd3373259426;

	localparam logic [10:0] ROW_FREQ [4] = '{11'd697, 11'd770, 11'd852, 11'd941};
	localparam logic [10:0] COL_FREQ [4] = '{11'd1209, 11'd1336, 11'd1477, 11'd1633};

	// (2i)(2i+1) for the odd taylor terms x^3 .. x^17
	localparam logic [63:0] TAYLOR_DIV [8] = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
	};

	localparam int unsigned QUEUE_DEPTH = 4;

endpackage

>>> rtl/dtmf_tone_generator_top.sv
// dtmf tone generator, one audio sample per request
//
// input stream: s_axis_tdata[3:0] is the dtmf symbol (row tone in bits 3..2,
// column tone in bits 1..0), s_axis_tuser[0] restarts both tones at phase zero
// for this sample. output stream: m_axis_tdata is the signed 16-bit sample,
// row tone plus column tone with wrap.
// apb port: register 0 at address 0 is the 15-bit amplitude of each tone;
// write it only while no request is in flight.
//
// a request is taken every cycle while the four-entry queue between the
// phase front end and the table/scaling back end has room. its sample
// passes the queue and then the back end, one sample per cycle sustained
// while the receiver keeps up; the back end is a four-stage pipe (table read,
// multiply, divide by full scale, sum).
// when the receiver stalls, the result is held in the output register and
// the back end stops; the front keeps taking requests until the queue fills.
// reset clears both phases, sets amplitude to 16383 and drops pending work.
module dtmf_tone_generator_top #(
	parameter int unsigned SINE_TABLE_DEPTH = 1024,
	parameter int unsigned PHASE_BITS       = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [7:0]                    s_axis_tdata,   // tone_symbol[3:0], zero pad
	input  logic [0:0]                    s_axis_tuser,   // restart
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [15:0]                   m_axis_tdata,   // sample[15:0]
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [dtmf_pkg::ADDR_W-1:0]   paddr,
	input  logic [dtmf_pkg::DATA_W-1:0]   pwdata,
	output logic [dtmf_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);
	import dtmf_pkg::*;

	localparam int unsigned IDX_W = $clog2(SINE_TABLE_DEPTH);

	logic [AMP_W-1:0]   amplitude_q;
	logic               q_push;
	logic [2*IDX_W-1:0] q_in;
	logic               q_not_full;
	logic               q_pop;
	logic               q_not_empty;
	logic [2*IDX_W-1:0] q_out;

	assign pready        = 1'b1;
	assign prdata        = (paddr[2] == REG_AMPLITUDE) ? DATA_W'(amplitude_q) : '0;
	assign s_axis_tready = q_not_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amplitude_q <= AMP_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_AMPLITUDE) begin
			amplitude_q <= pwdata[AMP_W-1:0];
		end
	end

	dtmf_front #(
		.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
		.PHASE_BITS      (PHASE_BITS),
		.IDX_W           (IDX_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_symbol (s_axis_tdata[SYM_W-1:0]),
		.in_restart(s_axis_tuser[0]),
		.q_ready   (q_not_full),
		.q_push    (q_push),
		.q_data    (q_in)
	);

	dtmf_queue #(
		.WIDTH(2 * IDX_W)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_in),
		.not_full (q_not_full),
		.pop      (q_pop),
		.not_empty(q_not_empty),
		.pop_data (q_out)
	);

	dtmf_back #(
		.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
		.IDX_W           (IDX_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.amplitude (amplitude_q),
		.q_valid   (q_not_empty),
		.q_data    (q_out),
		.q_pop     (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_sample(m_axis_tdata)
	);

endmodule

>>> rtl/dtmf_front.sv
module dtmf_front #(
	parameter int unsigned SINE_TABLE_DEPTH = 1024,
	parameter int unsigned PHASE_BITS       = 32,
	parameter int unsigned IDX_W            = $clog2(SINE_TABLE_DEPTH)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [dtmf_pkg::SYM_W-1:0] in_symbol,
	input  logic                      in_restart,
	input  logic                      q_ready,
	output logic                      q_push,
	output logic [2*IDX_W-1:0]        q_data
);
	import dtmf_pkg::*;

	localparam int unsigned PROD_W = PHASE_BITS + IDX_W + 1;

	function automatic logic [PHASE_BITS-1:0] step_of(input logic [10:0] f);
		logic [63:0] num;
		num = (64'(f) << PHASE_BITS) + (SAMPLE_RATE >> 1);
		return PHASE_BITS'(num / SAMPLE_RATE);
	endfunction

	localparam logic [PHASE_BITS-1:0] ROW_STEP [4] = '{
		step_of(ROW_FREQ[0]), step_of(ROW_FREQ[1]), step_of(ROW_FREQ[2]), step_of(ROW_FREQ[3])
	};
	localparam logic [PHASE_BITS-1:0] COL_STEP [4] = '{
		step_of(COL_FREQ[0]), step_of(COL_FREQ[1]), step_of(COL_FREQ[2]), step_of(COL_FREQ[3])
	};

	logic [PHASE_BITS-1:0] row_phase_q;
	logic [PHASE_BITS-1:0] col_phase_q;
	logic [PHASE_BITS-1:0] row_cur;
	logic [PHASE_BITS-1:0] col_cur;
	logic [PROD_W-1:0]     row_prod;
	logic [PROD_W-1:0]     col_prod;

	assign q_push  = in_valid && q_ready;
	assign row_cur = in_restart ? '0 : row_phase_q;
	assign col_cur = in_restart ? '0 : col_phase_q;

	assign row_prod = PROD_W'(row_cur) * PROD_W'(SINE_TABLE_DEPTH);
	assign col_prod = PROD_W'(col_cur) * PROD_W'(SINE_TABLE_DEPTH);
	assign q_data   = {col_prod[PHASE_BITS +: IDX_W], row_prod[PHASE_BITS +: IDX_W]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_phase_q <= '0;
			col_phase_q <= '0;
		end else if (q_push) begin
			row_phase_q <= row_cur + ROW_STEP[in_symbol[3:2]];
			col_phase_q <= col_cur + COL_STEP[in_symbol[1:0]];
		end
	end

endmodule

>>> rtl/dtmf_queue.sv
module dtmf_queue #(
	parameter int unsigned WIDTH = 20
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             not_full,
	input  logic             pop,
	output logic             not_empty,
	output logic [WIDTH-1:0] pop_data
);
	import dtmf_pkg::*;

	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign not_full  = count_q != CNT_W'(QUEUE_DEPTH);
	assign not_empty = count_q != '0;
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/dtmf_back.sv
module dtmf_back #(
	parameter int unsigned SINE_TABLE_DEPTH = 1024,
	parameter int unsigned IDX_W            = $clog2(SINE_TABLE_DEPTH)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [dtmf_pkg::AMP_W-1:0]    amplitude,
	input  logic                          q_valid,
	input  logic [2*IDX_W-1:0]            q_data,
	output logic                          q_pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [dtmf_pkg::SAMPLE_W-1:0] out_sample
);
	import dtmf_pkg::*;

	localparam logic [63:0] ROM_HALF_DIV = 64'(2 * SINE_TABLE_DEPTH);
	localparam logic [63:0] ROM_DEPTH    = 64'(SINE_TABLE_DEPTH);

	typedef logic signed [15:0] rom_t [SINE_TABLE_DEPTH];

	function automatic logic [15:0] quarter_sine(input logic [63:0] m);
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        term;
		logic [63:0]        r;
		logic signed [63:0] acc;
		x    = (m * PI_Q30 + ROM_DEPTH) / ROM_HALF_DIV;
		x2   = (x * x) >> 30;
		term = x;
		acc  = $signed(x);
		for (int i = 0; i < 8; i++) begin
			term = ((term * x2) >> 30) / TAYLOR_DIV[i];
			if (i % 2 == 0) begin
				acc = acc - $signed(term);
			end else begin
				acc = acc + $signed(term);
			end
		end
		if (acc < 0) begin
			acc = 0;
		end
		r = ($unsigned(acc) * FULL_SCALE + (64'd1 << 29)) >> 30;
		if (r > FULL_SCALE) begin
			r = FULL_SCALE;
		end
		return r[15:0];
	endfunction

	function automatic rom_t build_rom();
		rom_t        rom;
		logic [63:0] q;
		logic [63:0] quad;
		logic [63:0] rem;
		logic [63:0] m;
		logic [15:0] v;
		for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
			q    = 64'(4 * k);
			quad = q / ROM_DEPTH;
			rem  = q % ROM_DEPTH;
			m    = quad[0] ? ROM_DEPTH - rem : rem;
			v    = quarter_sine(m);
			rom[k] = (quad >= 64'd2) ? -$signed(v) : $signed(v);
		end
		return rom;
	endfunction

	localparam rom_t SINE_ROM = build_rom();

	logic                     en;
	logic                     valid_s1;
	logic                     valid_s2;
	logic                     valid_s3;
	logic signed [15:0]       rom_s1   [2];
	logic [2*AMP_W-1:0]       prod_s2  [2];
	logic                     neg_s2   [2];
	logic [SAMPLE_W-1:0]      tone_s3  [2];
	logic [AMP_W-1:0]         mag      [2];
	logic [2*AMP_W:0]         est      [2];
	logic [15:0]              quo_lo   [2];
	logic [2*AMP_W:0]         rem_est  [2];
	logic [15:0]              quo      [2];
	logic                     out_valid_q;
	logic [SAMPLE_W-1:0]      out_sample_q;

	assign en         = !out_valid_q || out_ready;
	assign q_pop      = q_valid && en;
	assign out_valid  = out_valid_q;
	assign out_sample = out_sample_q;

	always_comb begin
		for (int t = 0; t < 2; t++) begin
			mag[t] = rom_s1[t][15] ? AMP_W'(-rom_s1[t]) : AMP_W'(rom_s1[t]);
			// divide by full scale: estimate, then one correction
			est[t]     = {1'b0, prod_s2[t]} + (2*AMP_W+1)'(prod_s2[t] >> AMP_W);
			quo_lo[t]  = est[t][2*AMP_W -: 16];
			rem_est[t] = {1'b0, prod_s2[t]} - {quo_lo[t], 15'b0} + (2*AMP_W+1)'(quo_lo[t]);
			quo[t]     = (rem_est[t] >= (2*AMP_W+1)'(FULL_SCALE)) ? quo_lo[t] + 1'b1 : quo_lo[t];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rom_s1[0] <= SINE_ROM[q_data[IDX_W-1:0]];
			rom_s1[1] <= SINE_ROM[q_data[2*IDX_W-1:IDX_W]];
			for (int t = 0; t < 2; t++) begin
				prod_s2[t] <= mag[t] * amplitude;
				neg_s2[t]  <= rom_s1[t][15];
				tone_s3[t] <= neg_s2[t] ? -quo[t] : quo[t];
			end
			out_sample_q <= tone_s3[0] + tone_s3[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_s1    <= q_valid;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3;
		end
	end

endmodule

>>> rtl/dtmf_checker.sv
module dtmf_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_axis_tvalid,
	input logic                        s_axis_tready,
	input logic                        m_axis_tvalid,
	input logic                        m_axis_tready,
	input logic [15:0]                 m_axis_tdata,
	input logic                        psel,
	input logic                        penable,
	input logic                        pwrite,
	input logic [dtmf_pkg::ADDR_W-1:0] paddr,
	input logic [dtmf_pkg::DATA_W-1:0] pwdata,
	input logic [dtmf_pkg::DATA_W-1:0] prdata,
	input logic                        pready
);
	import dtmf_pkg::*;

	logic       in_acc;
	logic       out_acc;
	logic [3:0] pending_q;

	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign out_acc = m_axis_tvalid && m_axis_tready;

	// requests taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_acc && !out_acc) begin
			pending_q <= pending_q + 1'b1;
		end else if (out_acc && !in_acc) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	a_no_spurious_out: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> pending_q != 4'd0)
		else $error("result without pending request");

	a_bounded_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 4'(QUEUE_DEPTH + 4))
		else $error("too many requests in flight");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

	a_amp_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready && !paddr[2] |=>
			paddr[2] || prdata == DATA_W'($past(pwdata[AMP_W-1:0])))
		else $error("amplitude readback mismatch");

endmodule

bind dtmf_tone_generator_top dtmf_checker u_dtmf_checker (.*);

>>> tb/sv/dtmf_tone_generator_top_test.sv
`timescale 1ns / 1ps

module dtmf_tone_generator_top_test;

	import dtmf_pkg::*;

	localparam int unsigned TABLE_DEPTH = 1024;
	localparam int unsigned PHASE_W     = 32;
	localparam int unsigned INDEX_W     = $clog2(TABLE_DEPTH);
	localparam logic        SPARE_REG   = 1'b1;

	logic                clk;
	logic                arst_n;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [7:0]          s_axis_tdata;   // tone_symbol[3:0], zero pad
	logic [0:0]          s_axis_tuser;   // restart
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	logic [15:0]         m_axis_tdata;   // sample[15:0]
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	logic signed [15:0]  sine_lut [TABLE_DEPTH];
	logic [PHASE_W-1:0]  row_phase_model;
	logic [PHASE_W-1:0]  column_phase_model;
	logic [AMP_W-1:0]    amplitude_setting;
	logic [15:0]         expected_samples [$];
	int unsigned         errors;
	bit                  tx_idling;
	bit                  rx_idling;
	int unsigned         rx_hold;
	int unsigned         rx_stall;

	dtmf_tone_generator_top #(
		.SINE_TABLE_DEPTH(TABLE_DEPTH),
		.PHASE_BITS(PHASE_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("dtmf_tone_generator_top_test failed");
		$finish;
	end

	// first-quadrant sine, scaled to 0..32767
	function automatic logic [63:0] quarter_wave(input logic [63:0] m);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] r;
		longint      total;
		int          k;
		x = (m * PI_Q30 + 64'(TABLE_DEPTH)) / (64'(2 * TABLE_DEPTH));
		x2 = (x * x) >> 30;
		term = x;
		total = x;
		for (k = 1; k <= 8; k++) begin
			term = ((term * x2) >> 30) / TAYLOR_DIV[k-1];
			if (k % 2 == 1)
				total = total - longint'(term);
			else
				total = total + longint'(term);
		end
		if (total < 0)
			total = 0;
		r = (64'(total) * FULL_SCALE + (64'd1 << 29)) >> 30;
		if (r > FULL_SCALE)
			r = FULL_SCALE;
		return r;
	endfunction

	function automatic void fill_sine_lut();
		int unsigned k;
		int unsigned quad;
		int unsigned rem;
		int unsigned m;
		int          v;
		for (k = 0; k < TABLE_DEPTH; k++) begin
			quad = (4 * k) / TABLE_DEPTH;
			rem = (4 * k) % TABLE_DEPTH;
			m = quad[0] ? TABLE_DEPTH - rem : rem;
			v = int'(quarter_wave(64'(m)));
			sine_lut[k] = 16'((quad >= 2) ? -v : v);
		end
	endfunction

	function automatic logic [PHASE_W-1:0] phase_increment(input logic [10:0] freq);
		logic [63:0] wide;
		wide = ((64'(freq) << PHASE_W) + SAMPLE_RATE / 2) / SAMPLE_RATE;
		return wide[PHASE_W-1:0];
	endfunction

	function automatic int tone_level(input logic [PHASE_W-1:0] phase);
		int s;
		int mag;
		s = sine_lut[phase[PHASE_W-1 -: INDEX_W]];
		mag = (s < 0) ? -s : s;
		mag = (mag * int'(amplitude_setting)) / int'(FULL_SCALE);
		return (s < 0) ? -mag : mag;
	endfunction

	function automatic logic [15:0] predict_sample(input logic [3:0] symbol,
			input logic restart);
		int total;
		if (restart) begin
			row_phase_model = '0;
			column_phase_model = '0;
		end
		total = tone_level(row_phase_model) + tone_level(column_phase_model);
		row_phase_model = row_phase_model + phase_increment(ROW_FREQ[symbol[3:2]]);
		column_phase_model = column_phase_model + phase_increment(COL_FREQ[symbol[1:0]]);
		return total[15:0];
	endfunction

	function automatic int unsigned idle_length();
		if ($urandom_range(0, 15) == 0)
			return $urandom_range(10, 40);
		return $urandom_range(1, 3);
	endfunction

	task automatic send_request(input logic [3:0] symbol, input logic restart);
		int unsigned gap;
		gap = (tx_idling && $urandom_range(0, 3) == 0) ? idle_length() : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'b0000, symbol};
		s_axis_tuser <= restart;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		expected_samples = {expected_samples, predict_sample(symbol, restart)};
	endtask

	task automatic stop_requests();
		s_axis_tvalid <= 1'b0;
	endtask

	task automatic wait_for_samples();
		int unsigned n;
		n = 0;
		while (expected_samples.size() > 0 && n < 5000) begin
			@(posedge clk);
			n++;
		end
		if (expected_samples.size() > 0) begin
			$error("sample: %0d expected results never arrived", expected_samples.size());
			errors++;
			expected_samples.delete();
		end
		repeat (8) @(posedge clk);
	endtask

	task automatic write_register(input logic reg_index, input logic [DATA_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({reg_index, 2'b00});
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (reg_index == REG_AMPLITUDE)
			amplitude_setting = value[AMP_W-1:0];
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_amplitude_readback();
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ADDR_W'({REG_AMPLITUDE, 2'b00});
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata !== DATA_W'(amplitude_setting)) begin
			$error("amplitude: expected %0d, actual %0d", amplitude_setting, prdata);
			errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// one stretch of tones, mostly well formed: restart then a run of one symbol
	task automatic play_tones(input int unsigned item_count);
		int unsigned sent;
		int unsigned run;
		int unsigned k;
		logic [3:0]  symbol;
		logic        restart;
		sent = 0;
		while (sent < item_count) begin
			symbol = 4'($urandom_range(0, 15));
			run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200) :
				$urandom_range(4, 40);
			tx_idling = ($urandom_range(0, 2) != 0);
			rx_idling = ($urandom_range(0, 2) != 0);
			for (k = 0; k < run && sent < item_count; k++) begin
				restart = (k == 0) ? ($urandom_range(0, 7) != 0) : 1'b0;
				if ($urandom_range(0, 31) == 0) begin
					symbol = 4'($urandom_range(0, 15));
					restart = 1'($urandom_range(0, 1));
				end
				send_request(symbol, restart);
				sent++;
			end
		end
		stop_requests();
	endtask

	task automatic test_reset_state();
		tx_idling = 1'b0;
		rx_idling = 1'b0;
		check_amplitude_readback();
		send_request(4'd5, 1'b1);
		send_request(4'd5, 1'b0);
		send_request(4'd5, 1'b0);
		stop_requests();
		wait_for_samples();
	endtask

	task automatic test_every_symbol();
		int k;
		tx_idling = 1'b1;
		rx_idling = 1'b1;
		for (k = 0; k < 16; k++)
			send_request(4'(k), k == 0);
		stop_requests();
		wait_for_samples();
	endtask

	task automatic test_amplitude_limits();
		tx_idling = 1'b0;
		rx_idling = 1'b0;
		write_register(REG_AMPLITUDE, 32'd0);
		check_amplitude_readback();
		send_request(4'd10, 1'b1);
		send_request(4'd10, 1'b0);
		stop_requests();
		wait_for_samples();
		// upper bits of the write are dropped
		write_register(REG_AMPLITUDE, 32'hFFFF_FFFF);
		// a write to the spare address leaves amplitude alone
		write_register(SPARE_REG, 32'h0000_0005);
		check_amplitude_readback();
		send_request(4'd15, 1'b1);
		send_request(4'd15, 1'b0);
		send_request(4'd15, 1'b0);
		stop_requests();
		wait_for_samples();
	endtask

	task automatic test_back_pressure();
		write_register(REG_AMPLITUDE, 32'(AMP_RESET));
		tx_idling = 1'b0;
		rx_idling = 1'b0;
		rx_hold = 300;
		send_request(4'($urandom_range(0, 15)), 1'b1);
		repeat (79)
			send_request(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
		stop_requests();
		wait_for_samples();
	endtask

	task automatic test_random_tones();
		logic [DATA_W-1:0] levels [5];
		int k;
		levels[0] = 32'd32767;
		levels[1] = 32'd1;
		levels[2] = 32'($urandom_range(0, 32767));
		levels[3] = $urandom | 32'hFFFF_8000;
		levels[4] = 32'd16384;
		for (k = 0; k < 5; k++) begin
			write_register(REG_AMPLITUDE, levels[k]);
			check_amplitude_readback();
			play_tones(190);
			wait_for_samples();
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_samples.size() == 0) begin
				$error("sample: unexpected result %0d", $signed(m_axis_tdata));
				errors++;
			end else begin
				if (m_axis_tdata !== expected_samples[0]) begin
					$error("sample: expected %0d, actual %0d",
						$signed(expected_samples[0]), $signed(m_axis_tdata));
					errors++;
				end
				void'(expected_samples.pop_front());
			end
		end
	end

	// output back pressure
	initial begin
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold > 0) begin
				rx_stall = rx_hold;
				rx_hold = 0;
			end else if (rx_stall == 0 && rx_idling && $urandom_range(0, 3) == 0) begin
				rx_stall = idle_length();
			end
			if (rx_stall > 0) begin
				m_axis_tready <= 1'b0;
				rx_stall--;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin
		errors = 0;
		tx_idling = 1'b0;
		rx_idling = 1'b0;
		rx_hold = 0;
		rx_stall = 0;
		row_phase_model = '0;
		column_phase_model = '0;
		amplitude_setting = AMP_RESET;
		fill_sine_lut();
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_every_symbol();
		test_amplitude_limits();
		test_back_pressure();
		test_random_tones();
		if (errors == 0)
			$display("dtmf_tone_generator_top_test passed");
		else
			$display("dtmf_tone_generator_top_test failed");
		$finish;
	end

endmodule

>>> filelist.f
rtl/dtmf_pkg.sv
rtl/dtmf_front.sv
rtl/dtmf_queue.sv
rtl/dtmf_back.sv
rtl/dtmf_tone_generator_top.sv
rtl/dtmf_checker.sv
tb/sv/dtmf_tone_generator_top_test.sv
